/* hw/rtl/aobm_pkg.sv */
package aobm_pkg;

    // Default sizing of the bank
    localparam int VOICES_DEF       = 8;
    localparam int PHASE_BITS_DEF   = 24;
    localparam int SINE_DEPTH_DEF   = 256;

    // Configuration port
    localparam int CFG_INDEX_W      = 1;
    localparam int CFG_DATA_W       = 4;
    localparam logic [CFG_INDEX_W-1:0] REG_VOICE_COUNT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_PLAY_ENABLE = 1'b1;

    // Item kind carried on tuser
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // Input field widths and tdata layout
    localparam int SLOT_W      = 3;
    localparam int SHAPE_W     = 2;
    localparam int STEP_W      = 24;
    localparam int GAIN_W      = 16;
    localparam int OFF_SLOT    = 0;
    localparam int OFF_SHAPE   = OFF_SLOT + SLOT_W;
    localparam int OFF_STEP    = OFF_SHAPE + SHAPE_W;
    localparam int OFF_GAIN    = OFF_STEP + STEP_W;
    localparam int OFF_CLEAR   = OFF_GAIN + GAIN_W;
    localparam int S_TDATA_W   = 48;

    // Sample arithmetic
    localparam int SAMPLE_W    = 16;
    localparam int SINE_W      = 15;
    localparam int Q_FRAC      = 15;
    localparam int PROD_W      = 33;
    localparam int DIV_RADIX_BITS = 4;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX  = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN  = 16'sh8000;
    localparam logic signed [SAMPLE_W-1:0] SQUARE_POS  = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SQUARE_NEG  = 16'sh8001;

    typedef enum logic [1:0] {
        SHAPE_SINE     = 2'd0,
        SHAPE_SQUARE   = 2'd1,
        SHAPE_TRIANGLE = 2'd2,
        SHAPE_SAW      = 2'd3
    } wave_shape_t;

    // Controller to datapath commands
    typedef struct packed {
        logic write_voice;
        logic acc_clear;
        logic issue;
        logic div_load;
        logic div_step;
        logic out_load;
        logic out_zero;
    } aobm_cmd_t;

    function automatic int acc_width(input int voices);
        return PROD_W + $clog2(voices + 1);
    endfunction

    function automatic int div_width(input int voices);
        return ((acc_width(voices) - Q_FRAC + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS)
               * DIV_RADIX_BITS;
    endfunction

    // Quarter-wave entry i of a table of 2**lg entries, Q30 odd polynomial
    function automatic logic [SINE_W-1:0] sine_entry(input int unsigned i,
                                                     input int unsigned lg);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] r;
        x  = (64'(2 * i + 1) << 29) >> lg;
        x2 = (x * x) >> 30;
        t  = 64'd5026995;
        t  = 64'd85569306   - ((x2 * t) >> 30);
        t  = 64'd693598668  - ((x2 * t) >> 30);
        t  = 64'd1686629713 - ((x2 * t) >> 30);
        s  = (x * t) >> 30;
        if (s > (64'd1 << 30)) begin
            s = 64'd1 << 30;
        end
        r = (s * 64'd32767 + (64'd1 << 29)) >> 30;
        return r[SINE_W-1:0];
    endfunction

endpackage

/* hw/rtl/aobm_wave.sv */
module aobm_wave #(
    parameter int PHASE_BITS       = aobm_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = aobm_pkg::SINE_DEPTH_DEF
) (
    input  logic [PHASE_BITS-1:0]              phase,
    input  logic [aobm_pkg::SHAPE_W-1:0]       shape,
    output logic signed [aobm_pkg::SAMPLE_W-1:0] wave
);

    localparam int LG = $clog2(SINE_TABLE_DEPTH);

    logic [aobm_pkg::SINE_W-1:0]   sine_rom [SINE_TABLE_DEPTH];
    logic [1:0]                    quad;
    logic [LG-1:0]                 sine_idx;
    logic [aobm_pkg::SINE_W-1:0]   sine_mag;
    logic signed [aobm_pkg::SAMPLE_W-1:0] sine_val;
    logic [PHASE_BITS+16:0]        tri_ext;
    logic [16:0]                   tri_u;
    logic signed [17:0]            tri_fall;
    logic signed [aobm_pkg::SAMPLE_W-1:0] tri_val;
    logic [PHASE_BITS+15:0]        saw_ext;
    logic [15:0]                   saw_u;

    for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++) begin : g_rom
        assign sine_rom[gi] = aobm_pkg::sine_entry(gi, LG);
    end

    // Sine: quadrant from the top bits, mirror odd quadrants, negate the upper half
    assign quad     = phase[PHASE_BITS-1 -: 2];
    assign sine_idx = quad[0] ? ~phase[PHASE_BITS-3 -: LG] : phase[PHASE_BITS-3 -: LG];
    assign sine_mag = sine_rom[sine_idx];
    assign sine_val = quad[1] ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});

    assign tri_ext  = {phase, 17'd0};
    assign tri_u    = tri_ext[PHASE_BITS+16:PHASE_BITS];
    assign tri_fall = 18'sd65536 - $signed({1'b0, tri_u});

    always_comb begin
        if (!tri_u[16] && !tri_u[15]) begin
            tri_val = $signed(tri_u[15:0]);
        end else if (tri_u[16] && tri_u[15]) begin
            // upper quarter: plain two's complement of the 17-bit ramp
            tri_val = $signed(tri_u[15:0]);
        end else if (tri_fall == 18'sd32768) begin
            tri_val = aobm_pkg::SAMPLE_MAX;
        end else begin
            tri_val = tri_fall[15:0];
        end
    end

    assign saw_ext = {phase, 16'd0};
    assign saw_u   = saw_ext[PHASE_BITS+15:PHASE_BITS];

    always_comb begin
        case (aobm_pkg::wave_shape_t'(shape))
            aobm_pkg::SHAPE_SINE: begin
                wave = sine_val;
            end
            aobm_pkg::SHAPE_SQUARE: begin
                wave = phase[PHASE_BITS-1] ? aobm_pkg::SQUARE_NEG : aobm_pkg::SQUARE_POS;
            end
            aobm_pkg::SHAPE_TRIANGLE: begin
                wave = tri_val;
            end
            aobm_pkg::SHAPE_SAW: begin
                wave = $signed({~saw_u[15], saw_u[14:0]});
            end
            default: begin
                wave = '0;
            end
        endcase
    end

endmodule

/* hw/rtl/aobm_datapath.sv */
module aobm_datapath #(
    parameter int VOICES           = aobm_pkg::VOICES_DEF,
    parameter int PHASE_BITS       = aobm_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = aobm_pkg::SINE_DEPTH_DEF,
    localparam int VIDX_W          = (VOICES > 1) ? $clog2(VOICES) : 1,
    localparam int CNT_W           = $clog2(VOICES + 1)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  aobm_pkg::aobm_cmd_t                 cmd,
    input  logic [VIDX_W-1:0]                   voice_sel,
    input  logic [CNT_W-1:0]                    divisor,
    input  logic [aobm_pkg::SLOT_W-1:0]         wr_slot,
    input  logic [aobm_pkg::SHAPE_W-1:0]        wr_shape,
    input  logic [aobm_pkg::STEP_W-1:0]         wr_step,
    input  logic [aobm_pkg::GAIN_W-1:0]         wr_gain,
    input  logic                                wr_clear,
    output logic                                pipe_busy,
    output logic signed [aobm_pkg::SAMPLE_W-1:0] sample
);

    localparam int ACC_W  = aobm_pkg::acc_width(VOICES);
    localparam int DIV_W  = aobm_pkg::div_width(VOICES);
    localparam int SLOT_X = ((aobm_pkg::SLOT_W > VIDX_W) ? aobm_pkg::SLOT_W : VIDX_W) + 1;

    logic [PHASE_BITS-1:0]          phase_reg [VOICES];
    logic [PHASE_BITS-1:0]          step_reg  [VOICES];
    logic [aobm_pkg::SHAPE_W-1:0]   shape_reg [VOICES];
    logic [aobm_pkg::GAIN_W-1:0]    gain_reg  [VOICES];

    logic                           slot_ok;
    logic [VIDX_W-1:0]              wr_idx;
    logic signed [aobm_pkg::SAMPLE_W-1:0] wave;

    logic                           va_reg;
    logic                           vb_reg;
    logic signed [aobm_pkg::SAMPLE_W-1:0] w_reg;
    logic [aobm_pkg::GAIN_W-1:0]    g_reg;
    logic signed [aobm_pkg::PROD_W-1:0] prod_next;
    logic signed [aobm_pkg::PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]        acc_reg;
    logic signed [ACC_W-1:0]        acc_next;
    logic [ACC_W-1:0]               acc_abs;

    logic [DIV_W-1:0]               quo_reg;
    logic [DIV_W-1:0]               quo_next;
    logic [CNT_W-1:0]               rem_reg;
    logic [CNT_W-1:0]               rem_next;
    logic                           neg_reg;
    logic [DIV_W-1:0]               q_work;
    logic [CNT_W-1:0]               r_work;
    logic [CNT_W:0]                 r_wide;

    logic signed [aobm_pkg::SAMPLE_W-1:0] sat_val;
    logic signed [aobm_pkg::SAMPLE_W-1:0] sample_reg;

    assign slot_ok = SLOT_X'(wr_slot) < SLOT_X'(VOICES);
    assign wr_idx  = VIDX_W'(wr_slot);

    // Voice settings and phases
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int v = 0; v < VOICES; v++) begin
                phase_reg[v] <= '0;
                step_reg[v]  <= '0;
                shape_reg[v] <= '0;
                gain_reg[v]  <= '0;
            end
        end else begin
            if (cmd.write_voice && slot_ok) begin
                shape_reg[wr_idx] <= wr_shape;
                step_reg[wr_idx]  <= PHASE_BITS'(wr_step);
                gain_reg[wr_idx]  <= wr_gain;
                if (wr_clear) begin
                    phase_reg[wr_idx] <= '0;
                end
            end
            if (cmd.issue) begin
                phase_reg[voice_sel] <= phase_reg[voice_sel] + step_reg[voice_sel];
            end
        end
    end

    aobm_wave #(
        .PHASE_BITS       (PHASE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_wave (
        .phase (phase_reg[voice_sel]),
        .shape (shape_reg[voice_sel]),
        .wave  (wave)
    );

    // Three-stage multiply-accumulate: wave, product, sum
    assign prod_next = $signed(aobm_pkg::PROD_W'(w_reg))
                     * $signed(aobm_pkg::PROD_W'({1'b0, g_reg}));
    assign acc_next  = acc_reg + ACC_W'(prod_reg);
    assign pipe_busy = va_reg | vb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else begin
            va_reg <= cmd.issue;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        w_reg    <= wave;
        g_reg    <= gain_reg[voice_sel];
        prod_reg <= prod_next;
        if (cmd.acc_clear) begin
            acc_reg <= '0;
        end else if (vb_reg) begin
            acc_reg <= acc_next;
        end
    end

    // Divide |sum| >> 15 by the voice count, four quotient bits a cycle
    assign acc_abs = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);

    always_comb begin
        q_work = quo_reg;
        r_work = rem_reg;
        r_wide = '0;
        for (int i = 0; i < aobm_pkg::DIV_RADIX_BITS; i++) begin
            r_wide = {r_work, q_work[DIV_W-1]};
            q_work = {q_work[DIV_W-2:0], 1'b0};
            if (r_wide >= {1'b0, divisor}) begin
                r_wide    = r_wide - {1'b0, divisor};
                q_work[0] = 1'b1;
            end
            r_work = r_wide[CNT_W-1:0];
        end
        quo_next = q_work;
        rem_next = r_work;
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            quo_reg <= DIV_W'(acc_abs >> aobm_pkg::Q_FRAC);
            rem_reg <= '0;
            neg_reg <= acc_reg[ACC_W-1];
        end else if (cmd.div_step) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    // Saturate the signed quotient to 16 bits
    always_comb begin
        if (!neg_reg) begin
            sat_val = (quo_reg > DIV_W'(32767)) ? aobm_pkg::SAMPLE_MAX
                                                : $signed(quo_reg[15:0]);
        end else begin
            sat_val = (quo_reg > DIV_W'(32768)) ? aobm_pkg::SAMPLE_MIN
                                                : -$signed(quo_reg[15:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_reg <= '0;
        end else if (cmd.out_load) begin
            sample_reg <= cmd.out_zero ? '0 : sat_val;
        end
    end

    assign sample = sample_reg;

endmodule

/* hw/rtl/aobm_ctrl.sv */
module aobm_ctrl #(
    parameter int VOICES  = aobm_pkg::VOICES_DEF,
    localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1,
    localparam int CNT_W  = $clog2(VOICES + 1)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic                                s_kind,
    input  logic                                cfg_we,
    input  logic [aobm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [aobm_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                pipe_busy,
    output aobm_pkg::aobm_cmd_t                 cmd,
    output logic [VIDX_W-1:0]                   voice_sel,
    output logic [CNT_W-1:0]                    divisor
);

    localparam int DIV_ITER = aobm_pkg::div_width(VOICES) / aobm_pkg::DIV_RADIX_BITS;
    localparam int ITER_W   = (DIV_ITER > 1) ? $clog2(DIV_ITER) : 1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_RUN   = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    logic [aobm_pkg::CFG_DATA_W-1:0] count_reg;
    logic                           play_reg;
    logic [VIDX_W-1:0]              voice_reg;
    logic [VIDX_W-1:0]              voice_next;
    logic [ITER_W-1:0]              iter_reg;
    logic [ITER_W-1:0]              iter_next;
    logic                           zero_reg;
    logic                           zero_next;
    logic                           m_valid_reg;
    logic [4:0]                     count_ext;
    logic [CNT_W-1:0]               n_eff;
    logic                           accept;
    logic                           last_voice;

    // A count above the bank acts as the bank size
    assign count_ext = 5'(count_reg);
    assign n_eff     = (count_ext > 5'(VOICES)) ? CNT_W'(VOICES) : CNT_W'(count_ext);

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign last_voice = (CNT_W'(voice_reg) + CNT_W'(1)) == n_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            play_reg  <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                aobm_pkg::REG_VOICE_COUNT: begin
                    count_reg <= cfg_data;
                end
                aobm_pkg::REG_PLAY_ENABLE: begin
                    play_reg <= cfg_data[0];
                end
                default: begin
                    count_reg <= count_reg;
                end
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        voice_next = voice_reg;
        iter_next  = iter_reg;
        zero_next  = zero_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_kind == aobm_pkg::KIND_WRITE) begin
                        cmd.write_voice = 1'b1;
                    end else if (play_reg && (n_eff != '0)) begin
                        cmd.acc_clear = 1'b1;
                        voice_next    = '0;
                        zero_next     = 1'b0;
                        state_next    = ST_RUN;
                    end else begin
                        zero_next  = 1'b1;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_RUN: begin
                cmd.issue = 1'b1;
                if (last_voice) begin
                    state_next = ST_DRAIN;
                end else begin
                    voice_next = voice_reg + VIDX_W'(1);
                end
            end
            ST_DRAIN: begin
                // wait for the last product to reach the accumulator
                if (!pipe_busy) begin
                    cmd.div_load = 1'b1;
                    iter_next    = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (iter_reg == ITER_W'(DIV_ITER - 1)) begin
                    state_next = ST_DONE;
                end else begin
                    iter_next = iter_reg + ITER_W'(1);
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    cmd.out_zero = zero_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            voice_reg   <= '0;
            iter_reg    <= '0;
            zero_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            voice_reg <= voice_next;
            iter_reg  <= iter_next;
            zero_reg  <= zero_next;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid  = m_valid_reg;
    assign voice_sel = voice_reg;
    assign divisor   = n_eff;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_tready))
        else $error("result register overwritten while pending");

    a_issue_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.issue |-> (CNT_W'(voice_reg) < n_eff))
        else $error("voice issued beyond active count");

    a_div_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_load |-> !pipe_busy)
        else $error("divider loaded before accumulation finished");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside completion state");
`endif

endmodule

/* hw/rtl/additive_oscillator_bank_mixer_core.sv */
// Additive oscillator bank: up to VOICES phase-accumulator voices mixed into
// one signed Q1.15 sample stream.
// Input channel (s_): s_tuser selects the item kind, 0 a sample tick, 1 a
// voice write. A write loads one voice's shape, phase step and gain (and can
// zero its phase) in the cycle it transfers and produces no output.
// A tick produces one sample on the m_ channel. With play on and n active
// voices, a tick steps each voice in turn through the shared
// wave/multiply/accumulate pipeline, drains it, runs the divider (four
// quotient bits a cycle) and then loads the output register. A silent tick
// (play off or no active voice) only loads a zero sample.
// One item is worked on at a time; s_tready is high only while the block is
// idle, and it stays high while a finished sample waits on m_tvalid.
// Ticks can thus transfer only once the previous item is done, writes one
// per cycle while the block is idle.
// If the receiver stalls, the sample holds in the output register and the
// next tick finishes and waits until that sample is taken.
// Configuration writes (voice_count, play_enable) are registered and are
// meant for idle periods only.
// Reset clears all voice settings and phases, the control registers and the output.
module additive_oscillator_bank_mixer_core #(
    parameter int VOICES           = aobm_pkg::VOICES_DEF,
    parameter int PHASE_BITS       = aobm_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = aobm_pkg::SINE_DEPTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // voice_index, wave_shape, phase_step, gain, clear_phase (then zero fill)
    input  logic [aobm_pkg::S_TDATA_W-1:0]       s_tdata,
    // kind
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // sample
    output logic [aobm_pkg::SAMPLE_W-1:0]        m_tdata,
    input  logic                                 cfg_we,
    input  logic [aobm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [aobm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CNT_W  = $clog2(VOICES + 1);

    aobm_pkg::aobm_cmd_t                  cmd;
    logic                                 pipe_busy;
    logic [VIDX_W-1:0]                    voice_sel;
    logic [CNT_W-1:0]                     divisor;
    logic signed [aobm_pkg::SAMPLE_W-1:0] sample;

    aobm_ctrl #(
        .VOICES (VOICES)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_kind    (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .pipe_busy (pipe_busy),
        .cmd       (cmd),
        .voice_sel (voice_sel),
        .divisor   (divisor)
    );

    aobm_datapath #(
        .VOICES           (VOICES),
        .PHASE_BITS       (PHASE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .voice_sel (voice_sel),
        .divisor   (divisor),
        .wr_slot   (s_tdata[aobm_pkg::OFF_SLOT  +: aobm_pkg::SLOT_W]),
        .wr_shape  (s_tdata[aobm_pkg::OFF_SHAPE +: aobm_pkg::SHAPE_W]),
        .wr_step   (s_tdata[aobm_pkg::OFF_STEP  +: aobm_pkg::STEP_W]),
        .wr_gain   (s_tdata[aobm_pkg::OFF_GAIN  +: aobm_pkg::GAIN_W]),
        .wr_clear  (s_tdata[aobm_pkg::OFF_CLEAR]),
        .pipe_busy (pipe_busy),
        .sample    (sample)
    );

    assign m_tdata = sample;

endmodule
